// ----- rtl/movn_pkg.sv -----
// Shared types, constants and arithmetic helpers for the multi-octave value noise block.
// No dependencies; used by the interfaces, the octave cell and the top level.
package movn_pkg;

    // Default octave count of the chain
    localparam int MAX_OCTAVES_DEF = 8;

    // Configuration port geometry
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 3;

    // Field and datapath widths
    localparam int COORD_W  = 32;
    localparam int SEED_W   = 64;
    localparam int FREQ_W   = 32;
    localparam int AMP_W    = 32;
    localparam int CNT_CFG_W = 4;
    localparam int DECAY_W  = 16;
    localparam int CNT_W    = 5;     // holds the clamped octave count, at most 15
    localparam int FRAC_W   = 16;
    localparam int CORNER_W = 18;
    localparam int AB_W     = 36;
    localparam int MIX_W    = 54;
    localparam int NOISE_W  = 18;
    localparam int PROD_W   = 51;
    localparam int SUM_W    = 64;

    // Hash and corner mapping constants
    localparam logic [63:0] HASH_ADD    = 64'h0000_0000_9e37_79b9;
    localparam logic [13:0] MOD_RECIP   = 14'd8389;    // ceil(2^23 / 1000)
    localparam int          MOD_SHIFT   = 23;
    localparam logic [16:0] SCALE_RECIP = 17'd67109;   // ceil(2^26 / 1000)
    localparam int          SCALE_SHIFT = 26;

    // 2^(10k) mod 1000 for the 10-bit chunks of a 64-bit hash
    localparam logic [9:0] FOLD_K [7] = '{10'd1, 10'd24, 10'd576, 10'd824,
                                          10'd776, 10'd624, 10'd976};

    // Register indexes of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NOISE_SEED      = 3'd0,
        CFG_BASE_FREQUENCY  = 3'd1,
        CFG_BASE_AMPLITUDE  = 3'd2,
        CFG_OCTAVE_COUNT    = 3'd3,
        CFG_AMPLITUDE_DECAY = 3'd4
    } t_cfg_idx;

    // Sample context handed from one octave cell to the next
    typedef struct packed {
        logic                    valid;
        logic [CNT_W-1:0]        cnt;
        logic signed [63:0]      px;
        logic signed [63:0]      pz;
        logic [AMP_W-1:0]        amp;
        logic signed [SUM_W-1:0] sum;
    } t_carry;

    // One mixing step of the lattice hash
    function automatic logic [63:0] hash_step(input logic [63:0] h, input logic [63:0] c);
        return h ^ (c + HASH_ADD + (h << 6) + (h >> 2));
    endfunction

    // First reduction mod 1000: weighted sum of 10-bit chunks, congruent to h
    function automatic logic [22:0] fold_chunks(input logic [63:0] h);
        logic [22:0] acc;
        logic [9:0]  chunk;
        acc = '0;
        for (int k = 0; k < 7; k++) begin
            chunk = 10'(h >> (10 * k));
            acc   = acc + 23'(chunk) * 23'(FOLD_K[k]);
        end
        return acc;
    endfunction

    // Two more folds bring the value under 8192, still congruent mod 1000
    function automatic logic [12:0] fold_small(input logic [22:0] r);
        logic [17:0] r2;
        r2 = 18'(r[9:0]) + 18'(r[22:10]) * 18'd24;
        return 13'(r2[9:0]) + 13'(r2[17:10]) * 13'd24;
    endfunction

    // Smoothstep in Q0.16 from t and t*t
    function automatic logic [FRAC_W-1:0] smooth(input logic [15:0] t, input logic [31:0] tt);
        logic [49:0] p;
        p = 50'(tt) * 50'(18'd196608 - {1'b0, t, 1'b0});
        return p[47:32];
    endfunction

endpackage

// ----- rtl/movn_coord_if.sv -----
// Coordinate channel: valid/ready handshake carrying one Q16.16 sample point.
// Depends on movn_pkg for field widths.
interface movn_coord_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [movn_pkg::COORD_W-1:0]  coord_x;
    logic signed [movn_pkg::COORD_W-1:0]  coord_z;

    modport source (output valid, output coord_x, output coord_z, input ready);
    modport sink   (input valid, input coord_x, input coord_z, output ready);
endinterface

// ----- rtl/movn_noise_if.sv -----
// Result channel: valid/ready handshake carrying one saturated Q16.16 noise value.
// Depends on movn_pkg for field widths.
interface movn_noise_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [movn_pkg::COORD_W-1:0]  noise_value;

    modport source (output valid, output noise_value, input ready);
    modport sink   (input valid, input noise_value, output ready);
endinterface

// ----- rtl/movn_cell.sv -----
// One octave cell: hashes the four lattice corners, blends them and adds the
// weighted octave into the running sum if cnt > IDX. Depends on movn_pkg.
module movn_cell #(
    parameter int IDX = 0
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic [movn_pkg::SEED_W-1:0]       i_seed,
    input  logic [movn_pkg::DECAY_W-1:0]      i_decay,
    input  movn_pkg::t_carry                  i_carry,
    output movn_pkg::t_carry                  o_carry
);

    localparam int CELL_SH = 48 - IDX;   // Q.32 product to lattice cell
    localparam int FRAC_LO = 32 - IDX;   // lowest bit of the 16-bit fraction
    localparam int DLY     = 10;

    // Context delay line, entry k lines up with datapath stage k+1
    movn_pkg::t_carry r_dly [DLY];
    movn_pkg::t_carry r_out;

    // Stage 1: cell split, first hash step, fraction squares
    logic [63:0] w_seed, w_x0, w_x1, w_z0;
    logic [15:0] w_tx, w_tz;
    logic [63:0] r_h1a, r_h1b, r_z0;
    logic [15:0] r_tx, r_tz;
    logic [31:0] r_ttx, r_ttz;

    assign w_seed = i_seed + 64'(IDX);
    assign w_x0   = 64'(i_carry.px >>> CELL_SH);
    assign w_z0   = 64'(i_carry.pz >>> CELL_SH);
    assign w_x1   = w_x0 + 64'd1;
    assign w_tx   = i_carry.px[FRAC_LO +: 16];
    assign w_tz   = i_carry.pz[FRAC_LO +: 16];

    // Corner order: 0 = (x0,z0), 1 = (x0+1,z0), 2 = (x0,z0+1), 3 = (x0+1,z0+1)
    logic [63:0]                           r_h    [4];
    logic [22:0]                           r_r1   [4];
    logic [12:0]                           r_r3   [4];
    logic [9:0]                            r_v    [4];
    logic [16:0]                           r_mm   [4];
    logic [16:0]                           r_v131 [4];
    logic signed [movn_pkg::CORNER_W-1:0]  r_corner [4];
    logic [movn_pkg::FRAC_W-1:0]           r_fx [6];
    logic [movn_pkg::FRAC_W-1:0]           r_fz [7];

    // Per-corner combinational helpers
    logic [26:0] w_qp [4];
    logic [3:0]  w_q  [4];
    logic [33:0] w_sp [4];
    logic [6:0]  w_q2 [4];
    logic signed [18:0] w_cs [4];

    always_comb begin
        for (int j = 0; j < 4; j++) begin
            w_qp[j] = 27'(r_r3[j]) * 27'(movn_pkg::MOD_RECIP);
            w_q[j]  = 4'(w_qp[j] >> movn_pkg::MOD_SHIFT);
            w_sp[j] = 34'(r_mm[j]) * 34'(movn_pkg::SCALE_RECIP);
            w_q2[j] = 7'(w_sp[j] >> movn_pkg::SCALE_SHIFT);
            w_cs[j] = $signed({2'b00, r_v131[j]}) + $signed({12'd0, w_q2[j]}) - 19'sd65536;
        end
    end

    // Bilinear blend along x, then along z
    logic signed [18:0]                 w_d0, w_d1;
    logic signed [16:0]                 w_fx17, w_fz17;
    logic signed [movn_pkg::AB_W-1:0]   w_pa, w_pb, w_a, w_b, r_a, r_b;
    logic signed [movn_pkg::AB_W:0]     w_dab;
    logic signed [movn_pkg::MIX_W-1:0]  w_pm, w_ash, w_m, r_m, w_mr;
    logic signed [movn_pkg::NOISE_W-1:0] w_n;
    logic signed [32:0]                 w_amp33;
    logic signed [movn_pkg::PROD_W-1:0] w_prod, r_prod;
    logic [47:0]                        w_ad;
    logic                               w_oct_on;

    assign w_d0   = r_corner[1];
    assign w_d1   = r_corner[3];
    assign w_fx17 = $signed({1'b0, r_fx[5]});
    assign w_fz17 = $signed({1'b0, r_fz[6]});
    assign w_pa   = (w_d0 - 19'(r_corner[0])) * w_fx17;
    assign w_pb   = (w_d1 - 19'(r_corner[2])) * w_fx17;
    assign w_a    = (36'(r_corner[0]) <<< 16) + w_pa;
    assign w_b    = (36'(r_corner[2]) <<< 16) + w_pb;

    assign w_dab  = r_b - r_a;
    assign w_pm   = w_dab * w_fz17;
    assign w_ash  = r_a;
    assign w_m    = (w_ash <<< 16) + w_pm;

    // Round the Q.48 blend to Q.16 and weight by the octave amplitude
    assign w_mr    = r_m + 54'sd2147483648;
    assign w_n     = w_mr[49:32];
    assign w_amp33 = $signed({1'b0, r_dly[8].amp});
    assign w_prod  = w_n * w_amp33;

    // Accumulate and decay
    assign w_ad     = r_dly[DLY-1].amp * i_decay;
    assign w_oct_on = r_dly[DLY-1].cnt > movn_pkg::CNT_W'(IDX);

    // Outgoing context with the updated sum and amplitude
    movn_pkg::t_carry n_out;

    always_comb begin
        n_out     = r_dly[DLY-1];
        n_out.sum = r_dly[DLY-1].sum + (w_oct_on ? 64'(r_prod) : 64'sd0);
        n_out.amp = w_ad[47:16];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DLY; k++) begin
                r_dly[k].valid <= 1'b0;
            end
            r_out.valid <= 1'b0;
        end else if (i_en) begin
            r_dly[0] <= i_carry;
            for (int k = 1; k < DLY; k++) begin
                r_dly[k] <= r_dly[k-1];
            end
            r_out <= n_out;
        end
    end

    // Datapath stages
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // stage 1
            r_h1a <= movn_pkg::hash_step(w_seed, w_x0);
            r_h1b <= movn_pkg::hash_step(w_seed, w_x1);
            r_z0  <= w_z0;
            r_tx  <= w_tx;
            r_tz  <= w_tz;
            r_ttx <= 32'(w_tx) * 32'(w_tx);
            r_ttz <= 32'(w_tz) * 32'(w_tz);
            // stage 2
            r_h[0]  <= movn_pkg::hash_step(r_h1a, r_z0);
            r_h[1]  <= movn_pkg::hash_step(r_h1b, r_z0);
            r_h[2]  <= movn_pkg::hash_step(r_h1a, r_z0 + 64'd1);
            r_h[3]  <= movn_pkg::hash_step(r_h1b, r_z0 + 64'd1);
            r_fx[0] <= movn_pkg::smooth(r_tx, r_ttx);
            r_fz[0] <= movn_pkg::smooth(r_tz, r_ttz);
            for (int k = 1; k < 6; k++) begin
                r_fx[k] <= r_fx[k-1];
            end
            for (int k = 1; k < 7; k++) begin
                r_fz[k] <= r_fz[k-1];
            end
            // stages 3 to 7: mod 1000 and corner mapping
            for (int j = 0; j < 4; j++) begin
                r_r1[j]     <= movn_pkg::fold_chunks(r_h[j]);
                r_r3[j]     <= movn_pkg::fold_small(r_r1[j]);
                r_v[j]      <= 10'(r_r3[j] - 13'(w_q[j]) * 13'd1000);
                r_mm[j]     <= 17'(r_v[j]) * 17'd72 + 17'd500;
                r_v131[j]   <= 17'(r_v[j]) * 17'd131;
                r_corner[j] <= w_cs[j][17:0];
            end
            // stages 8 to 10
            r_a    <= w_a;
            r_b    <= w_b;
            r_m    <= w_m;
            r_prod <= w_prod;
        end
    end

    assign o_carry = r_out;

endmodule

// ----- rtl/multi_octave_value_noise.sv -----
// Multi-octave 2-D value noise, top level: configuration registers, input
// product stage, the chain of octave cells and the rounding output register.
// Depends on movn_pkg, movn_coord_if, movn_noise_if and movn_cell.
//
// Usage:
//   i_coord carries one (coord_x, coord_z) pair in signed Q16.16 per
//   transaction; o_noise returns one saturated Q16.16 sum per transaction,
//   in the same order.
//   The frequency product registers at the accepting edge; the transaction then
//   passes through the octave cells and is rounded into the output register.
//   Throughput is one transaction per cycle unless the receiver stalls; every cell
//   is a fixed-depth pipeline and the whole chain advances together.
//   When the receiver stalls with a result held, the chain freezes and
//   i_coord.ready drops until the result is taken.
//   Registers are written via i_cfg_we / i_cfg_idx / i_cfg_data, by the user only
//   with no transaction in flight (not enforced); unknown indexes are ignored.
//   Synchronous reset clears the pipeline valid bits and loads the register
//   defaults: seed 0, frequency and amplitude 1.0, 4 octaves, decay 0.5.
module multi_octave_value_noise #(
    parameter int MAX_OCTAVES = movn_pkg::MAX_OCTAVES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    movn_coord_if.sink                        i_coord,
    movn_noise_if.source                      o_noise,
    input  logic                              i_cfg_we,
    input  logic [movn_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [movn_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    // Configuration registers
    logic [movn_pkg::SEED_W-1:0]    r_noise_seed;
    logic [movn_pkg::FREQ_W-1:0]    r_base_frequency;
    logic [movn_pkg::AMP_W-1:0]     r_base_amplitude;
    logic [movn_pkg::CNT_CFG_W-1:0] r_octave_count;
    logic [movn_pkg::DECAY_W-1:0]   r_amplitude_decay;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_noise_seed      <= '0;
            r_base_frequency  <= 32'd65536;
            r_base_amplitude  <= 32'd65536;
            r_octave_count    <= 4'd4;
            r_amplitude_decay <= 16'd32768;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                movn_pkg::CFG_NOISE_SEED:      r_noise_seed      <= i_cfg_data;
                movn_pkg::CFG_BASE_FREQUENCY:  r_base_frequency  <= 32'(i_cfg_data);
                movn_pkg::CFG_BASE_AMPLITUDE:  r_base_amplitude  <= 32'(i_cfg_data);
                movn_pkg::CFG_OCTAVE_COUNT:    r_octave_count    <= 4'(i_cfg_data);
                movn_pkg::CFG_AMPLITUDE_DECAY: r_amplitude_decay <= 16'(i_cfg_data);
                default: ;
            endcase
        end
    end

    // Chain advances whenever the output register is free or being drained
    logic w_adv;
    logic r_o_valid;
    logic signed [31:0] r_o_value;

    assign w_adv         = !r_o_valid || o_noise.ready;
    assign i_coord.ready = w_adv;

    // Front stage: scale both coordinates by the base frequency
    logic signed [64:0]          w_px, w_pz;
    logic [movn_pkg::CNT_W-1:0]  w_cnt;
    movn_pkg::t_carry            r_front;

    assign w_px  = i_coord.coord_x * $signed({1'b0, r_base_frequency});
    assign w_pz  = i_coord.coord_z * $signed({1'b0, r_base_frequency});
    assign w_cnt = (movn_pkg::CNT_W'(r_octave_count) > movn_pkg::CNT_W'(MAX_OCTAVES))
                 ? movn_pkg::CNT_W'(MAX_OCTAVES) : movn_pkg::CNT_W'(r_octave_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front.valid <= 1'b0;
        end else if (w_adv) begin
            r_front.valid <= i_coord.valid;
            r_front.cnt   <= w_cnt;
            r_front.px    <= w_px[63:0];
            r_front.pz    <= w_pz[63:0];
            r_front.amp   <= r_base_amplitude;
            r_front.sum   <= '0;
        end
    end

    // Octave cells
    movn_pkg::t_carry w_chain [MAX_OCTAVES+1];
    assign w_chain[0] = r_front;

    for (genvar gi = 0; gi < MAX_OCTAVES; gi++) begin : g_cell
        movn_cell #(
            .IDX (gi)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_adv),
            .i_seed  (r_noise_seed),
            .i_decay (r_amplitude_decay),
            .i_carry (w_chain[gi]),
            .o_carry (w_chain[gi+1])
        );
    end

    // Round Q.32 sum to Q16.16 and saturate
    logic signed [63:0] w_rs;
    logic signed [47:0] w_rq;
    logic signed [31:0] w_res;

    assign w_rs = w_chain[MAX_OCTAVES].sum + 64'sd32768;
    assign w_rq = w_rs[63:16];

    always_comb begin
        if (w_rq > 48'sd2147483647) begin
            w_res = 32'sh7fff_ffff;
        end else if (w_rq < -48'sd2147483648) begin
            w_res = 32'sh8000_0000;
        end else begin
            w_res = w_rq[31:0];
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_adv) begin
            r_o_valid <= w_chain[MAX_OCTAVES].valid;
            r_o_value <= w_res;
        end
    end

    assign o_noise.valid       = r_o_valid;
    assign o_noise.noise_value = r_o_value;

`ifndef NO_ASSERTIONS
    // A frozen chain must not move the last cell's transaction
    a_chain_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> $stable(w_chain[MAX_OCTAVES].valid))
        else $error("octave chain moved while stalled");

    // With no octaves the sum stays zero
    a_zero_oct: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_noise.valid && r_octave_count == 4'd0) |-> o_noise.noise_value == 32'sd0)
        else $error("nonzero result with zero octaves");
`endif

endmodule

// ----- bench/movn_tb_types.sv -----
`timescale 1ns / 1ps
// Bench-side view of the value noise block: the coordinate pair of one input sample.
// Depends on movn_pkg only for the coordinate width.
package movn_tb_types;
    typedef struct packed {
        logic signed [movn_pkg::COORD_W-1:0] x;
        logic signed [movn_pkg::COORD_W-1:0] z;
    } t_sample;
endpackage

// ----- bench/multi_octave_value_noise_tb.sv -----
`timescale 1ns / 1ps
// Testbench for multi_octave_value_noise: directed and random coordinate samples under
// several register settings, checked against a fixed-point fBm predictor in the bench.
// Depends on movn_pkg, movn_coord_if, movn_noise_if, movn_tb_types and the RTL.
module multi_octave_value_noise_tb;

    localparam int LATENCY = 1 + 11 * movn_pkg::MAX_OCTAVES_DEF;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [movn_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [movn_pkg::CFG_DATA_W-1:0] i_cfg_data;

    movn_coord_if i_coord ();
    movn_noise_if o_noise ();

    multi_octave_value_noise DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_coord(i_coord.sink), .o_noise(o_noise.source),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    // Bench copy of the registers
    logic [63:0] seed_q;
    logic [31:0] freq_q;
    logic [31:0] amp_q;
    logic [3:0]  octaves_q;
    logic [15:0] decay_q;

    logic signed [31:0] noise_expected_q [$];
    int errors = 0;
    int hold_req;

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR %0t: %s", $realtime, msg);
        errors++;
    endtask

    // floor(v / 2^s) for signed 64-bit values
    function automatic logic signed [63:0] asr_floor(input logic signed [63:0] v, input int s);
        return v >>> s;
    endfunction

    // Corner value in Q2.16 from lattice cell and seed
    function automatic logic signed [63:0] lattice_corner(input logic signed [63:0] cx,
                                                          input logic signed [63:0] cz,
                                                          input logic [63:0] sd);
        logic [63:0] h;
        logic [63:0] v;
        h = sd;
        h = h ^ (64'(cx) + 64'h9e3779b9 + (h << 6) + (h >> 2));
        h = h ^ (64'(cz) + 64'h9e3779b9 + (h << 6) + (h >> 2));
        v = h % 64'd1000;
        return $signed((v * 64'd131072 + 64'd500) / 64'd1000) - 64'sd65536;
    endfunction

    function automatic logic signed [63:0] ease(input logic [63:0] t);
        logic [63:0] p;
        p = t * t * (64'd196608 - 64'd2 * t);
        return $signed(p >> 32);
    endfunction

    // One octave of lattice noise, Q2.16
    function automatic logic signed [63:0] octave_value(input logic signed [63:0] sx,
                                                        input logic signed [63:0] sz,
                                                        input logic [63:0] sd);
        logic signed [63:0] x0, z0, fx, fz, a, b, m;
        x0 = asr_floor(sx, 16);
        z0 = asr_floor(sz, 16);
        fx = ease(64'(sx[15:0]));
        fz = ease(64'(sz[15:0]));
        a = lattice_corner(x0, z0, sd) * (64'sd65536 - fx) + lattice_corner(x0 + 1, z0, sd) * fx;
        b = lattice_corner(x0, z0 + 1, sd) * (64'sd65536 - fx)
          + lattice_corner(x0 + 1, z0 + 1, sd) * fx;
        m = a * (64'sd65536 - fz) + b * fz;
        return asr_floor(m + 64'sd2147483648, 32);
    endfunction

    function automatic logic signed [31:0] fbm_noise(input movn_tb_types::t_sample s);
        logic signed [63:0] px, pz, sum, res;
        logic [63:0] amp;
        int cnt;
        px = 64'(s.x) * $signed({32'd0, freq_q});
        pz = 64'(s.z) * $signed({32'd0, freq_q});
        cnt = (octaves_q > movn_pkg::MAX_OCTAVES_DEF) ? movn_pkg::MAX_OCTAVES_DEF
                                                      : int'(octaves_q);
        amp = 64'(amp_q);
        sum = 0;
        for (int i = 0; i < cnt; i++) begin
            sum += octave_value(asr_floor(px, 32 - i), asr_floor(pz, 32 - i), seed_q + 64'(i))
                   * $signed(amp);
            amp = (amp * 64'(decay_q)) >> 16;
        end
        res = asr_floor(sum + 64'sd32768, 16);
        if (res > 64'sd2147483647) res = 64'sd2147483647;
        if (res < -64'sd2147483648) res = -64'sd2147483648;
        return res[31:0];
    endfunction

    // Gap of random length: mostly short, a few long
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Send one coordinate transaction; expectation queued at acceptance
    task automatic send_sample(input movn_tb_types::t_sample s);
        int g;
        g = gap_len();
        if (g > 0) begin
            i_coord.valid <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
        i_coord.valid   <= 1'b1;
        i_coord.coord_x <= s.x;
        i_coord.coord_z <= s.z;
        do @(posedge i_clk); while (!i_coord.ready);
        noise_expected_q.push_back(fbm_noise(s));
        @(negedge i_clk);
    endtask

    task automatic wait_drain();
        i_coord.valid <= 1'b0;
        while (noise_expected_q.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 5) @(negedge i_clk);
    endtask

    task automatic write_reg(input movn_pkg::t_cfg_idx idx, input logic [63:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            movn_pkg::CFG_NOISE_SEED:      seed_q    = val;
            movn_pkg::CFG_BASE_FREQUENCY:  freq_q    = val[31:0];
            movn_pkg::CFG_BASE_AMPLITUDE:  amp_q     = val[31:0];
            movn_pkg::CFG_OCTAVE_COUNT:    octaves_q = val[3:0];
            movn_pkg::CFG_AMPLITUDE_DECAY: decay_q   = val[15:0];
            default: ;
        endcase
    endtask

    task automatic set_all(input logic [63:0] sd, input logic [31:0] fr, input logic [31:0] am,
                           input logic [3:0] oc, input logic [15:0] dc);
        write_reg(movn_pkg::CFG_NOISE_SEED, sd);
        write_reg(movn_pkg::CFG_BASE_FREQUENCY, {32'd0, fr});
        write_reg(movn_pkg::CFG_BASE_AMPLITUDE, {32'd0, am});
        write_reg(movn_pkg::CFG_OCTAVE_COUNT, {60'd0, oc});
        write_reg(movn_pkg::CFG_AMPLITUDE_DECAY, {48'd0, dc});
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
            2: return {{8{$urandom_range(0, 1) == 1}}, 24'($urandom())};
            default: return 32'($signed($urandom_range(0, 600)) - 300) <<< 16;
        endcase
    endfunction

    function automatic movn_tb_types::t_sample rand_sample();
        movn_tb_types::t_sample s;
        s.x = rand_coord();
        s.z = rand_coord();
        return s;
    endfunction

    // Extremes of the coordinates, lattice boundaries, zero octaves, clamped count
    task automatic test_directed();
        logic [31:0] edges [6] = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff,
                                   32'h0001_0000, 32'h0000_ffff};
        foreach (edges[i]) send_sample('{x: edges[i], z: edges[5 - i]});
        send_sample('{x: 32'h7fff_ffff, z: 32'h7fff_ffff});
        send_sample('{x: 32'h8000_0000, z: 32'h8000_0000});
        wait_drain();
        write_reg(movn_pkg::CFG_OCTAVE_COUNT, 64'd0);
        send_sample('{x: 32'h1234_5678, z: 32'h8765_4321});
        wait_drain();
        write_reg(movn_pkg::CFG_OCTAVE_COUNT, 64'd15);
        write_reg(movn_pkg::t_cfg_idx'(3'd7), 64'hffff_ffff_ffff_ffff);
        send_sample('{x: 32'h0003_8000, z: 32'hfffc_8000});
        wait_drain();
        // Seed wrap and saturating totals
        set_all(64'hffff_ffff_ffff_fffc, 32'hffff_ffff, 32'hffff_ffff, 4'd8, 16'hffff);
        for (int i = 0; i < 6; i++) send_sample(rand_sample());
        send_sample('{x: 32'h8000_0000, z: 32'h7fff_ffff});
        wait_drain();
    endtask

    task automatic test_random_settings();
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: set_all(64'd0, 32'd65536, 32'd65536, 4'd4, 16'd32768);
                1: set_all({$urandom(), $urandom()}, $urandom(), $urandom(),
                           4'($urandom_range(0, 15)), 16'($urandom()));
                2: set_all(64'd0, 32'd0, 32'd0, 4'd1, 16'd0);
                3: set_all(64'hffff_ffff_ffff_ffff, 32'hffff_ffff, 32'h0001_0000, 4'd8,
                           16'h8000);
                default: set_all({$urandom(), $urandom()}, $urandom_range(0, 32'h0010_0000),
                                 $urandom_range(0, 32'h0004_0000),
                                 4'($urandom_range(1, 9)), 16'($urandom()));
            endcase
            for (int i = 0; i < 226; i++) send_sample(rand_sample());
            wait_drain();
        end
    endtask

    // Long receiver hold-off while the sender keeps offering
    task automatic test_backpressure();
        hold_req++;
        for (int i = 0; i < 120; i++) send_sample(rand_sample());
        wait_drain();
    endtask

    // Result checker and receiver stall generator
    always @(posedge i_clk) begin
        if (i_rst_n && o_noise.valid && o_noise.ready) begin
            if (noise_expected_q.size() == 0) begin
                report_mismatch("unexpected noise transaction");
            end else begin
                logic signed [31:0] want;
                want = noise_expected_q.pop_front();
                if (o_noise.noise_value !== want)
                    report_mismatch($sformatf("noise_value got %0d want %0d",
                                              o_noise.noise_value, want));
            end
        end
    end

    initial begin
        int n;
        int hold_done;
        hold_done = 0;
        o_noise.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req != hold_done) begin
                o_noise.ready <= 1'b0;
                for (n = 0; n < 200; n++) @(negedge i_clk);
                hold_done = hold_req;
            end
            n = gap_len();
            o_noise.ready <= (n == 0) || ($urandom_range(0, 1) == 1);
        end
    end

    initial begin
        hold_req = 0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        i_coord.valid = 1'b0;
        i_coord.coord_x = '0;
        i_coord.coord_z = '0;
        seed_q = 64'd0;
        freq_q = 32'd65536;
        amp_q = 32'd65536;
        octaves_q = 4'd4;
        decay_q = 16'd32768;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_random_settings();
        test_backpressure();
        wait_drain();
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial begin
        #20ms;
        $display("FAIL");
        $finish;
    end
endmodule

// ----- filelist.f -----
rtl/movn_pkg.sv
rtl/movn_coord_if.sv
rtl/movn_noise_if.sv
rtl/movn_cell.sv
rtl/multi_octave_value_noise.sv
bench/movn_tb_types.sv
bench/multi_octave_value_noise_tb.sv
